>>> sv/ttc_pkg.sv
// Shared types and constants of the lidar time-to-collision check.
// Used by the front, back and top-level modules; depends on nothing.
package ttc_pkg;

  // Item operation codes.
  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_CHECK = 2'd1,
    OP_CLEAR = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  // Threshold register reset value in microseconds.
  localparam logic [15:0] THR_RESET = 16'd5000;

  // Microseconds per second; the 2^15 of the Q1.15 cosine is a shift.
  localparam logic signed [20:0] US_PER_S = 21'sd1000000;
  localparam int unsigned        Q_SHIFT  = 15;

  // Queue depths and the widths of their fill counts.
  localparam int unsigned MID_DEPTH = 4;
  localparam int unsigned MID_CW    = $clog2(MID_DEPTH + 1);
  localparam int unsigned OUT_DEPTH = 4;
  localparam int unsigned OUT_CW    = $clog2(OUT_DEPTH + 1);

  // Classified item from the front, with its table entry already read.
  typedef struct packed {
    op_e                op;
    logic               in_range;
    logic               first;
    logic [15:0]        range_mm;
    logic signed [15:0] speed;
    logic signed [15:0] cosine;
    logic [15:0]        edge_mm;
    logic signed [12:0] angle;
  } item_t;

  // One result beat.
  typedef struct packed {
    logic               beam_hit;
    logic               collided;
    logic signed [12:0] hit_angle;
  } res_t;

endpackage

>>> sv/ttc_fifo.sv
// Small synchronous queue built from registers, used between the stages.
// Depends on nothing; the owner keeps push away from a full queue.
module ttc_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         push_i,
  input  logic [WIDTH-1:0]             wdata_i,
  input  logic                         pop_i,
  output logic [WIDTH-1:0]             rdata_o,
  output logic                         empty_o,
  output logic [$clog2(DEPTH+1)-1:0]   count_o
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0]    wr_ptr_q, wr_ptr_d;
  logic [PW-1:0]    rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]    cnt_q, cnt_d;

  // Pointer advance with wrap at the queue depth.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!push_i && pop_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Entry storage holds payload only.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  assign rdata_o = mem_q[rd_ptr_q];
  assign empty_o = (cnt_q == '0);
  assign count_o = cnt_q;

endmodule

>>> sv/ttc_front.sv
// Front end: accepts items, writes and reads the per-beam tables, and
// passes classified items on. Depends on ttc_pkg.
module ttc_front import ttc_pkg::*; #(
  parameter int unsigned BEAMS = 1080
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               accept_i,
  input  op_e                op_i,
  input  logic [10:0]        beam_index_i,
  input  logic               first_beam_i,
  input  logic [15:0]        range_mm_i,
  input  logic signed [15:0] speed_i,
  input  logic signed [15:0] load_cosine_i,
  input  logic [15:0]        load_edge_mm_i,
  input  logic signed [12:0] load_angle_i,
  output logic               valid_o,
  output item_t              item_o
);

  localparam int unsigned AW = (BEAMS > 1) ? $clog2(BEAMS) : 1;
  localparam int unsigned IW = (AW > 11) ? AW : 11;
  localparam int unsigned EW = 16 + 16 + 13;

  logic [EW-1:0] table_q [BEAMS];
  logic [EW-1:0] rd_q;
  logic [IW-1:0] idx_ext;
  logic [AW-1:0] addr;
  logic          in_range;

  logic               valid_q;
  op_e                op_q;
  logic               in_range_q;
  logic               first_q;
  logic [15:0]        range_q;
  logic signed [15:0] speed_q;

  // Table address and range check of the beam number.
  assign idx_ext  = IW'(beam_index_i);
  assign addr     = idx_ext[AW-1:0];
  assign in_range = (32'(beam_index_i) < 32'(BEAMS));

  // Beam tables: one write port for loads, one registered read per beat.
  always_ff @(posedge clk_i) begin
    if (accept_i && (op_i == OP_LOAD) && in_range) begin
      table_q[addr] <= {load_cosine_i, load_edge_mm_i, load_angle_i};
    end
    if (accept_i) begin
      rd_q <= table_q[addr];
    end
  end

  // Item payload travels alongside the table read.
  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      op_q       <= op_i;
      in_range_q <= in_range;
      first_q    <= first_beam_i;
      range_q    <= range_mm_i;
      speed_q    <= speed_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= accept_i;
    end
  end

  assign valid_o = valid_q;

  always_comb begin
    item_o          = '0;
    item_o.op       = op_q;
    item_o.in_range = in_range_q;
    item_o.first    = first_q;
    item_o.range_mm = range_q;
    item_o.speed    = speed_q;
    item_o.cosine   = $signed(rd_q[44:29]);
    item_o.edge_mm  = rd_q[28:13];
    item_o.angle    = $signed(rd_q[12:0]);
  end

endmodule

>>> sv/ttc_back.sv
// Back end: two arithmetic stages for the cross-multiplied time test, then
// the scan and collision state update. Depends on ttc_pkg.
module ttc_back import ttc_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [15:0]       thr_i,
  input  item_t             item_i,
  input  logic              item_empty_i,
  output logic              item_pop_o,
  input  logic [OUT_CW-1:0] out_count_i,
  output logic              out_push_o,
  output res_t              out_res_o
);

  // Stage A: projected speed and range margin.
  logic               a_valid_q;
  op_e                a_op_q;
  logic               a_in_range_q, a_first_q;
  logic signed [31:0] a_p_q;
  logic signed [16:0] a_n_q;
  logic signed [12:0] a_angle_q;

  // Stage B: both sides of the comparison.
  logic               b_valid_q;
  op_e                b_op_q;
  logic               b_in_range_q, b_first_q;
  logic signed [37:0] b_nm_q;
  logic signed [48:0] b_rhs_q;
  logic               b_p_pos_q, b_p_neg_q, b_n_neg_q, b_n_zero_q;
  logic signed [12:0] b_angle_q;

  logic signed [37:0] nm_d;
  logic signed [48:0] rhs_d;
  logic signed [53:0] lhs_ext, rhs_ext;
  logic               test_hit;

  // Scan and collision state.
  logic               scan_done_q, scan_done_d;
  logic               flag_q, flag_d;
  logic signed [12:0] angle_q, angle_d;
  logic               hit;
  logic               scan_eff;
  logic [OUT_CW+1:0]  in_flight;

  // Issue only when the output queue has room for everything in flight.
  assign in_flight  = (OUT_CW + 2)'(out_count_i) + (OUT_CW + 2)'(a_valid_q)
                    + (OUT_CW + 2)'(b_valid_q);
  assign item_pop_o = !item_empty_i && (in_flight < (OUT_CW + 2)'(OUT_DEPTH));

  always_ff @(posedge clk_i) begin
    a_op_q       <= item_i.op;
    a_in_range_q <= item_i.in_range;
    a_first_q    <= item_i.first;
    a_p_q        <= item_i.speed * item_i.cosine;
    a_n_q        <= $signed({1'b0, item_i.range_mm}) - $signed({1'b0, item_i.edge_mm});
    a_angle_q    <= item_i.angle;
  end

  // Range margin in microsecond units and threshold times projected speed.
  assign nm_d  = 38'(a_n_q) * 38'(US_PER_S);
  assign rhs_d = 49'($signed({1'b0, thr_i})) * 49'(a_p_q);

  always_ff @(posedge clk_i) begin
    b_op_q       <= a_op_q;
    b_in_range_q <= a_in_range_q;
    b_first_q    <= a_first_q;
    b_nm_q       <= nm_d;
    b_rhs_q      <= rhs_d;
    b_p_pos_q    <= (a_p_q > 32'sd0);
    b_p_neg_q    <= a_p_q[31];
    b_n_neg_q    <= a_n_q[16];
    b_n_zero_q   <= (a_n_q == 17'sd0);
    b_angle_q    <= a_angle_q;
  end

  // Time test: the Q1.15 scale enters as a left shift of the margin side.
  assign lhs_ext  = {b_nm_q[37], b_nm_q, Q_SHIFT'(0)};
  assign rhs_ext  = 54'(b_rhs_q);
  assign test_hit = (b_p_pos_q && !b_n_neg_q && (lhs_ext < rhs_ext))
                 || (b_p_neg_q && (b_n_neg_q || b_n_zero_q) && (lhs_ext > rhs_ext));

  // State update of the item leaving stage B.
  always_comb begin
    scan_done_d = scan_done_q;
    flag_d      = flag_q;
    angle_d     = angle_q;
    hit         = 1'b0;
    scan_eff    = scan_done_q && !b_first_q;
    case (b_op_q)
      OP_CHECK: begin
        hit         = !scan_eff && b_in_range_q && test_hit;
        scan_done_d = scan_eff || hit;
        if (hit) begin
          flag_d  = 1'b1;
          angle_d = b_angle_q;
        end
      end
      OP_CLEAR: begin
        flag_d = 1'b0;
      end
      default: begin
        flag_d = flag_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q   <= 1'b0;
      b_valid_q   <= 1'b0;
      scan_done_q <= 1'b0;
      flag_q      <= 1'b0;
      angle_q     <= '0;
    end else begin
      a_valid_q <= item_pop_o;
      b_valid_q <= a_valid_q;
      if (b_valid_q) begin
        scan_done_q <= scan_done_d;
        flag_q      <= flag_d;
        angle_q     <= angle_d;
      end
    end
  end

  assign out_push_o          = b_valid_q;
  assign out_res_o.beam_hit  = hit;
  assign out_res_o.collided  = flag_d;
  assign out_res_o.hit_angle = angle_d;

endmodule

>>> sv/lidar_time_to_collision_check.sv
// Lidar time-to-collision check: sustains one item per clock cycle, while
// not full, set by the one table read per item and the two pipelined multiply
// stages of the back end; a result passes the front read register, the mid
// queue and stages A and B into a four-beat output queue, so input keeps
// flowing while results wait. Per-beam tables of BEAMS entries are written
// by load items with no clearing pass after reset. The threshold is written
// over the configuration channel, which is always ready. Depends on ttc_pkg.
module lidar_time_to_collision_check import ttc_pkg::*; #(
  parameter int unsigned BEAMS = 1080
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // Item channel.
  input  logic               push,
  output logic               full,
  input  logic [1:0]         operation_i,
  input  logic [10:0]        beam_index_i,
  input  logic               first_beam_i,
  input  logic [15:0]        measured_range_mm_i,
  input  logic signed [15:0] speed_mm_s_i,
  input  logic signed [15:0] load_cosine_i,
  input  logic [15:0]        load_edge_mm_i,
  input  logic signed [12:0] load_angle_mrad_i,
  // Result channel.
  output logic               empty,
  input  logic               pop,
  output logic               beam_hit_o,
  output logic               collided_o,
  output logic signed [12:0] hit_angle_mrad_o,
  // Threshold write channel.
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [15:0]        cfg_data_i
);

  logic              accept;
  logic              front_valid;
  item_t             front_item;
  item_t             mid_item;
  logic              mid_empty;
  logic              mid_pop;
  logic [MID_CW-1:0] mid_count;
  logic [OUT_CW-1:0] out_count;
  logic              out_push;
  logic              out_pop;
  res_t              out_res_in;
  res_t              out_res;
  logic [15:0]       thr_q;

  // Input beat goes in only if the mid queue can hold it and the read stage.
  assign full   = ((MID_CW + 1)'(mid_count) + (MID_CW + 1)'(front_valid))
                  >= (MID_CW + 1)'(MID_DEPTH);
  assign accept = push && !full;

  // Threshold register.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= THR_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      thr_q <= cfg_data_i;
    end
  end

  ttc_front #(
    .BEAMS(BEAMS)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .accept_i       (accept),
    .op_i           (op_e'(operation_i)),
    .beam_index_i   (beam_index_i),
    .first_beam_i   (first_beam_i),
    .range_mm_i     (measured_range_mm_i),
    .speed_i        (speed_mm_s_i),
    .load_cosine_i  (load_cosine_i),
    .load_edge_mm_i (load_edge_mm_i),
    .load_angle_i   (load_angle_mrad_i),
    .valid_o        (front_valid),
    .item_o         (front_item)
  );

  // Queue between the classifying front and the arithmetic back.
  ttc_fifo #(
    .WIDTH($bits(item_t)),
    .DEPTH(MID_DEPTH)
  ) u_mid_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (front_valid),
    .wdata_i (front_item),
    .pop_i   (mid_pop),
    .rdata_o (mid_item),
    .empty_o (mid_empty),
    .count_o (mid_count)
  );

  ttc_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .thr_i        (thr_q),
    .item_i       (mid_item),
    .item_empty_i (mid_empty),
    .item_pop_o   (mid_pop),
    .out_count_i  (out_count),
    .out_push_o   (out_push),
    .out_res_o    (out_res_in)
  );

  // Result queue.
  assign out_pop = pop && !empty;

  ttc_fifo #(
    .WIDTH($bits(res_t)),
    .DEPTH(OUT_DEPTH)
  ) u_out_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (out_push),
    .wdata_i (out_res_in),
    .pop_i   (out_pop),
    .rdata_o (out_res),
    .empty_o (empty),
    .count_o (out_count)
  );

  assign beam_hit_o       = out_res.beam_hit;
  assign collided_o       = out_res.collided;
  assign hit_angle_mrad_o = out_res.hit_angle;

endmodule

>>> sv/ttc_checker.sv
// Port-level checks of the lidar time-to-collision check, bound to the
// top level. Depends only on the top level's ports.
module ttc_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               empty,
  input logic               pop,
  input logic               beam_hit_o,
  input logic               collided_o,
  input logic signed [12:0] hit_angle_mrad_o
);

  // A hit always reports the collision flag as set.
  a_hit_sets_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && beam_hit_o) |-> collided_o)
    else $error("beam hit without collision flag");

  // A waiting result beat holds until it is taken.
  a_result_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable({beam_hit_o, collided_o, hit_angle_mrad_o})))
    else $error("waiting result changed");

  // The latched angle changes only on a hit.
  a_angle_only_on_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((!empty && pop) ##1 (!empty && !beam_hit_o))
      |-> (hit_angle_mrad_o == $past(hit_angle_mrad_o)))
    else $error("angle changed without a hit");

  // The collision flag rises only with a hit.
  a_flag_rises_on_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((!empty && pop && !collided_o) ##1 !empty) |-> (!collided_o || beam_hit_o))
    else $error("collision flag set without a hit");

endmodule

bind lidar_time_to_collision_check ttc_checker u_ttc_checker (.*);
